FILE: sv/hch20_pkg.sv
package hch20_pkg;

	// standard round count, double rounds
	localparam int HCH_DOUBLE_ROUNDS = 10;

	localparam int WORD_W  = 32;
	localparam int WORDS   = 16;
	localparam int IN_W    = 384;
	localparam int OUT_W   = 256;

	typedef logic [WORD_W-1:0] word_t;
	typedef word_t [WORDS-1:0] state_t;

	// "expand 32-byte k"
	localparam word_t SIGMA_0 = 32'h61707865;
	localparam word_t SIGMA_1 = 32'h3320646E;
	localparam word_t SIGMA_2 = 32'h79622D32;
	localparam word_t SIGMA_3 = 32'h6B206574;

endpackage

FILE: sv/hch20_qround.sv
module hch20_qround
	import hch20_pkg::*;
(
	input  word_t a,
	input  word_t b,
	input  word_t c,
	input  word_t d,
	output word_t a_out,
	output word_t b_out,
	output word_t c_out,
	output word_t d_out
);

	word_t a1, b1, c1, d1, x1, y1;
	word_t a2, b2, c2, d2, x2, y2;

	always_comb begin
		a1 = a + b;
		x1 = d ^ a1;
		d1 = {x1[15:0], x1[31:16]};
		c1 = c + d1;
		y1 = b ^ c1;
		b1 = {y1[19:0], y1[31:20]};
		a2 = a1 + b1;
		x2 = d1 ^ a2;
		d2 = {x2[23:0], x2[31:24]};
		c2 = c1 + d2;
		y2 = b1 ^ c2;
		b2 = {y2[24:0], y2[31:25]};
	end

	assign a_out = a2;
	assign b_out = b2;
	assign c_out = c2;
	assign d_out = d2;

endmodule

FILE: sv/hch20_pass.sv
module hch20_pass
	import hch20_pkg::*;
#(
	parameter bit DIAG = 1'b0
)
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  state_t in_state,
	output logic   out_valid,
	input  logic   out_ready,
	output state_t out_state
);

	state_t next_state;
	state_t state_s1;
	logic   valid_s1;

	// column pass or diagonal pass, four quarter rounds side by side
	for (genvar j = 0; j < 4; j++) begin : g_qr
		localparam int SH = DIAG ? 1 : 0;
		localparam int IA = j;
		localparam int IB = 4 + ((j + SH) % 4);
		localparam int IC = 8 + ((j + 2 * SH) % 4);
		localparam int ID = 12 + ((j + 3 * SH) % 4);

		hch20_qround u_qr (
			.a     (in_state[IA]),
			.b     (in_state[IB]),
			.c     (in_state[IC]),
			.d     (in_state[ID]),
			.a_out (next_state[IA]),
			.b_out (next_state[IB]),
			.c_out (next_state[IC]),
			.d_out (next_state[ID])
		);
	end

	// stage takes a new item when empty or when its item moves on
	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			state_s1 <= next_state;
		end
	end

	assign out_valid = valid_s1;
	assign out_state = state_s1;

endmodule

FILE: sv/hchacha20_subkey_derivation.sv
// channel | dir | width | contents
// s_*     | in  | 384   | key_0 key_1 key_2 key_3 nonce_0 nonce_1, one derivation per transfer
// m_*     | out | 256   | subkey_0 subkey_1 subkey_2 subkey_3, one result per input transfer
//
// one transfer per cycle sustained while m_tready is high; one register stage per
// column or diagonal pass, each stage one quarter-round deep
// arst_n clears the stage valid bits only; no table or memory to clear
// a stall at m_tready backs up stage by stage: bubbles are squeezed out, so the
// input keeps taking transfers until every stage holds an item
module hchacha20_subkey_derivation
	import hch20_pkg::*;
#(
	parameter int DOUBLE_ROUNDS = HCH_DOUBLE_ROUNDS
)
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// key_0 [63:0], key_1 [127:64], key_2 [191:128], key_3 [255:192],
	// nonce_0 [319:256], nonce_1 [383:320]
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// subkey_0 [63:0], subkey_1 [127:64], subkey_2 [191:128], subkey_3 [255:192]
	output logic [OUT_W-1:0] m_tdata
);

	localparam int NUM_STAGES = 2 * DOUBLE_ROUNDS;

	// chain of handshakes between passes; index 0 is the input side
	logic [NUM_STAGES:0]   valid_chain;
	logic [NUM_STAGES:0]   ready_chain;
	state_t                stage_state [NUM_STAGES+1];
	logic [NUM_STAGES-1:0] stage_valid;
	state_t                init_state;
	state_t                final_state;

	// initial state: constants, then key and nonce as little-endian words
	always_comb begin
		init_state[0] = SIGMA_0;
		init_state[1] = SIGMA_1;
		init_state[2] = SIGMA_2;
		init_state[3] = SIGMA_3;
		for (int k = 0; k < 12; k++) begin
			init_state[4 + k] = s_tdata[WORD_W*k +: WORD_W];
		end
	end

	assign stage_state[0]          = init_state;
	assign valid_chain[0]          = s_tvalid;
	assign s_tready                = ready_chain[0];
	assign ready_chain[NUM_STAGES] = m_tready;

	// even stages run the column pass, odd stages the diagonal pass
	for (genvar i = 0; i < NUM_STAGES; i++) begin : g_pass
		hch20_pass #(
			.DIAG ((i % 2) == 1)
		) u_pass (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_chain[i]),
			.in_ready  (ready_chain[i]),
			.in_state  (stage_state[i]),
			.out_valid (valid_chain[i+1]),
			.out_ready (ready_chain[i+1]),
			.out_state (stage_state[i+1])
		);
	end

	assign stage_valid = valid_chain[NUM_STAGES:1];
	assign final_state = stage_state[NUM_STAGES];

	// last stage register is the output register; no feed-forward add
	assign m_tvalid = valid_chain[NUM_STAGES];
	assign m_tdata  = {final_state[15], final_state[14], final_state[13], final_state[12],
	                   final_state[3], final_state[2], final_state[1], final_state[0]};

`ifndef SYNTHESIS
	// input only stalls when every stage is full and the output is stalled
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (($countones(stage_valid) == NUM_STAGES) && !m_tready))
		else $error("input stalled with a free stage");

	// an accepted transfer with no output transfer adds one item in flight
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && !(m_tvalid && m_tready)) |=>
		($countones(stage_valid) == $past($countones(stage_valid)) + 1))
		else $error("item lost or duplicated on input");

	// an output transfer with no input transfer removes one item
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !(s_tvalid && s_tready)) |=>
		($countones(stage_valid) + 1 == $past($countones(stage_valid))))
		else $error("item lost or duplicated on output");
`endif

endmodule
